### hdl/hkrt_pkg.sv
package hkrt_pkg;

    localparam int ADC_BITS   = 12;
    localparam int FRAC_BITS  = 15;
    localparam int POS_W      = FRAC_BITS + 1;
    localparam int THR_W      = POS_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = 1;
    localparam int Q_CNT_W    = 2;
    localparam int DIV_CNT_W  = $clog2(FRAC_BITS);
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    localparam logic [POS_W-1:0] FULL_POS = POS_W'(1) << FRAC_BITS;

    localparam logic [CFG_IDX_W-1:0] CFG_CAL_LOW      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_HIGH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_MODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTUATION    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RT_PRESS     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RT_RELEASE   = 3'd6;

    localparam logic MODE_TRADITIONAL = 1'b0;
    localparam logic MODE_RAPID       = 1'b1;

    localparam logic FUNC_SAMPLE  = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        KIND_SAMPLE,
        KIND_ZERO,
        KIND_FULL,
        KIND_RELEASE
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [ADC_BITS-1:0]  num;
        logic [ADC_BITS-1:0]  den;
    } t_qentry;

    typedef struct packed {
        logic                 mode;
        logic [POS_W-1:0]     actuation;
        logic [POS_W-1:0]     hysteresis;
        logic [POS_W-1:0]     press_delta;
        logic [POS_W-1:0]     release_delta;
    } t_key_cfg;

endpackage

### hdl/hall_key_rapid_trigger.sv
// Channel   Dir  Handshake               Payload (lowest bit up)
// s_axis    in   tvalid/tready           tdata: adc_sample[11:0], zero pad to 16
//                                        tuser: func
// m_axis    out  tvalid/tready           tdata: key_pressed, key_position[15:0], zero pad
// cfg       in   i_cfg_we                i_cfg_index selects register, i_cfg_data value
//
// In the back unit a sample that needs division goes through pick, 15 quotient
// steps of the bit-serial divider, and update. Release, rest and full-travel items
// skip the divider and go from pick to update. The back unit runs one item at a
// time; a two-entry queue lets s_axis keep accepting while it works, and the output
// register holds a result while m_axis stalls.
// Synchronous active-low reset restores the default registers and clears key state.
module hall_key_rapid_trigger (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [hkrt_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // adc_sample, pad
    input  logic                             s_axis_tuser,   // func
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [hkrt_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // key_pressed, key_position, pad
    input  logic                             i_cfg_we,
    input  logic [hkrt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [hkrt_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import hkrt_pkg::*;

    logic [ADC_BITS-1:0] r_cal_low;
    logic [ADC_BITS-1:0] r_cal_high;
    logic                r_mode;
    logic [POS_W-1:0]    r_actuation;
    logic [POS_W-1:0]    r_hysteresis;
    logic [POS_W-1:0]    r_press_delta;
    logic [POS_W-1:0]    r_release_delta;

    t_key_cfg            w_cfg;
    logic                w_q_push;
    logic                w_q_full;
    logic                w_q_pop;
    logic                w_q_empty;
    t_qentry             w_push_entry;
    t_qentry             w_pop_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_low       <= '0;
            r_cal_high      <= ADC_BITS'(4095);
            r_mode          <= MODE_TRADITIONAL;
            r_actuation     <= POS_W'(16384);
            r_hysteresis    <= POS_W'(3277);
            r_press_delta   <= POS_W'(3277);
            r_release_delta <= POS_W'(3277);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CAL_LOW:      r_cal_low       <= i_cfg_data[ADC_BITS-1:0];
                CFG_CAL_HIGH:     r_cal_high      <= i_cfg_data[ADC_BITS-1:0];
                CFG_TRIGGER_MODE: r_mode          <= i_cfg_data[0];
                CFG_ACTUATION:    r_actuation     <= i_cfg_data[POS_W-1:0];
                CFG_HYSTERESIS:   r_hysteresis    <= i_cfg_data[POS_W-1:0];
                CFG_RT_PRESS:     r_press_delta   <= i_cfg_data[POS_W-1:0];
                CFG_RT_RELEASE:   r_release_delta <= i_cfg_data[POS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_cfg.mode          = r_mode;
    assign w_cfg.actuation     = r_actuation;
    assign w_cfg.hysteresis    = r_hysteresis;
    assign w_cfg.press_delta   = r_press_delta;
    assign w_cfg.release_delta = r_release_delta;

    hkrt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_cal_low     (r_cal_low),
        .i_cal_high    (r_cal_high),
        .i_q_full      (w_q_full),
        .o_q_push      (w_q_push),
        .o_q_entry     (w_push_entry)
    );

    hkrt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_entry (w_push_entry),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_entry (w_pop_entry),
        .o_empty (w_q_empty)
    );

    hkrt_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_q_empty     (w_q_empty),
        .i_q_entry     (w_pop_entry),
        .o_q_pop       (w_q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

### hdl/hkrt_front.sv
module hkrt_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [hkrt_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  logic                           s_axis_tuser,
    input  logic [hkrt_pkg::ADC_BITS-1:0]  i_cal_low,
    input  logic [hkrt_pkg::ADC_BITS-1:0]  i_cal_high,
    input  logic                           i_q_full,
    output logic                           o_q_push,
    output hkrt_pkg::t_qentry              o_q_entry
);
    import hkrt_pkg::*;

    logic                r_valid;
    t_qentry             r_entry;
    t_qentry             n_entry;
    logic [ADC_BITS-1:0] w_adc;
    logic                w_accept;

    assign w_adc         = s_axis_tdata[ADC_BITS-1:0];
    assign o_q_push      = r_valid && !i_q_full;
    assign s_axis_tready = !r_valid || !i_q_full;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign o_q_entry     = r_entry;

    // classify: release, at or below rest or bad calibration, at or beyond full, or divide
    always_comb begin
        n_entry.num  = w_adc - i_cal_low;
        n_entry.den  = i_cal_high - i_cal_low;
        if (s_axis_tuser == FUNC_RELEASE) begin
            n_entry.kind = KIND_RELEASE;
        end else if (i_cal_high <= i_cal_low || w_adc <= i_cal_low) begin
            n_entry.kind = KIND_ZERO;
        end else if (w_adc >= i_cal_high) begin
            n_entry.kind = KIND_FULL;
        end else begin
            n_entry.kind = KIND_SAMPLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_q_push) begin
            r_valid <= 1'b0;
        end
        if (w_accept) begin
            r_entry <= n_entry;
        end
    end

endmodule

### hdl/hkrt_queue.sv
module hkrt_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  hkrt_pkg::t_qentry i_entry,
    output logic              o_full,
    input  logic              i_pop,
    output hkrt_pkg::t_qentry o_entry,
    output logic              o_empty
);
    import hkrt_pkg::*;

    t_qentry              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic                 w_push;
    logic                 w_pop;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

### hdl/hkrt_back.sv
module hkrt_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  hkrt_pkg::t_key_cfg              i_cfg,
    input  logic                            i_q_empty,
    input  hkrt_pkg::t_qentry               i_q_entry,
    output logic                            o_q_pop,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [hkrt_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import hkrt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_UPD
    } t_state;

    t_state                r_state;
    t_kind                 r_kind;
    logic [ADC_BITS-1:0]   r_rem;
    logic [ADC_BITS-1:0]   r_den;
    logic [FRAC_BITS-1:0]  r_quo;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [POS_W-1:0]      r_pos;
    logic                  r_pressed;
    logic [POS_W-1:0]      r_peak;
    logic [POS_W-1:0]      r_valley;
    logic                  r_out_valid;
    logic                  r_out_pressed;
    logic [POS_W-1:0]      r_out_pos;

    logic [ADC_BITS:0]     w_rem2;
    logic                  w_ge;
    logic [ADC_BITS:0]     w_rem_sub;
    logic                  w_out_free;
    logic                  n_pressed;
    logic [POS_W-1:0]      n_peak;
    logic [POS_W-1:0]      n_valley;
    logic [POS_W-1:0]      w_peak_max;
    logic [POS_W-1:0]      w_valley_min;

    assign o_q_pop       = (r_state == ST_IDLE) && !i_q_empty;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_DATA_W - POS_W - 1)'(0), r_out_pos, r_out_pressed};

    // restoring division step: remainder stays below the divisor
    assign w_rem2    = {r_rem, 1'b0};
    assign w_ge      = (w_rem2 >= {1'b0, r_den});
    assign w_rem_sub = w_rem2 - {1'b0, r_den};

    assign w_peak_max   = (r_pos > r_peak) ? r_pos : r_peak;
    assign w_valley_min = (r_pos < r_valley) ? r_pos : r_valley;

    always_comb begin
        n_pressed = r_pressed;
        n_peak    = r_peak;
        n_valley  = r_valley;
        if (r_kind == KIND_RELEASE) begin
            n_pressed = 1'b0;
            n_peak    = '0;
            n_valley  = '0;
        end else if (i_cfg.mode == MODE_TRADITIONAL) begin
            if (!r_pressed) begin
                n_pressed = (r_pos >= i_cfg.actuation);
            end else if (({1'b0, r_pos} + {1'b0, i_cfg.hysteresis})
                         < {1'b0, i_cfg.actuation}) begin
                n_pressed = 1'b0;
            end
        end else if (r_pos == '0 || r_pos >= FULL_POS) begin
            n_peak    = r_pos;
            n_valley  = r_pos;
            n_pressed = (r_pos != '0);
        end else if (r_pressed) begin
            n_peak = w_peak_max;
            if (({1'b0, r_pos} + {1'b0, i_cfg.release_delta}) < {1'b0, w_peak_max}) begin
                n_pressed = 1'b0;
                n_valley  = r_pos;
            end
        end else begin
            n_valley = w_valley_min;
            if ({1'b0, r_pos} > ({1'b0, w_valley_min} + {1'b0, i_cfg.press_delta})) begin
                n_pressed = 1'b1;
                n_peak    = r_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pressed   <= 1'b0;
            r_peak      <= '0;
            r_valley    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_UPD && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (!i_q_empty) begin
                        r_kind <= i_q_entry.kind;
                        r_rem  <= i_q_entry.num;
                        r_den  <= i_q_entry.den;
                        r_cnt  <= '0;
                        case (i_q_entry.kind)
                            KIND_SAMPLE: begin
                                r_state <= ST_DIV;
                            end
                            KIND_FULL: begin
                                r_pos   <= FULL_POS;
                                r_state <= ST_UPD;
                            end
                            default: begin
                                r_pos   <= '0;
                                r_state <= ST_UPD;
                            end
                        endcase
                    end
                end
                ST_DIV: begin
                    r_rem <= w_ge ? w_rem_sub[ADC_BITS-1:0] : w_rem2[ADC_BITS-1:0];
                    r_quo <= {r_quo[FRAC_BITS-2:0], w_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DIV_CNT_W'(FRAC_BITS - 1)) begin
                        r_pos   <= {1'b0, r_quo[FRAC_BITS-2:0], w_ge};
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    if (w_out_free) begin
                        r_pressed     <= n_pressed;
                        r_peak        <= n_peak;
                        r_valley      <= n_valley;
                        r_out_pressed <= n_pressed;
                        r_out_pos     <= r_pos;
                        r_state       <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### tb/sv/hall_key_rapid_trigger_tb.sv
module hall_key_rapid_trigger_tb;
    import hkrt_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int HOLD_CYCLES = 300;
    localparam int SCRIPT_LEN  = 39;

    typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

    typedef struct packed {
        logic             pressed;
        logic [POS_W-1:0] position;
    } key_report_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   index;
        logic                   func;
        logic [CFG_DATA_W-1:0]  value;
        logic                   typed;
        logic                   exp_pressed;
        logic [POS_W-1:0]       exp_pos;
    } script_row_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;   // adc_sample, pad
    logic                   s_axis_tuser = FUNC_SAMPLE;   // func
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;   // key_pressed, key_position, pad
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = CFG_CAL_LOW;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // key model registers and tracking state
    logic [ADC_BITS-1:0]    cal_lo = 12'd0;
    logic [ADC_BITS-1:0]    cal_hi = 12'd4095;
    logic                   rapid_mode = MODE_TRADITIONAL;
    logic [15:0]            actuation_lvl = 16'd16384;
    logic [15:0]            hysteresis_lvl = 16'd3277;
    logic [15:0]            press_delta = 16'd3277;
    logic [15:0]            release_delta = 16'd3277;
    logic                   key_down = 1'b0;
    logic [POS_W-1:0]       peak_pos = '0;
    logic [POS_W-1:0]       valley_pos = '0;

    key_report_t            pending_reports[$];
    int                     items_sent = 0;
    int                     reports_seen = 0;
    int                     fail_count = 0;

    script_row_t script_rows [SCRIPT_LEN] = '{
        '{ROW_ITEM,  '0,               FUNC_SAMPLE,  16'd0,     1'b1, 1'b0, 16'd0},
        '{ROW_ITEM,  '0,               FUNC_SAMPLE,  16'd4095,  1'b1, 1'b1, 16'd32768},
        '{ROW_ITEM,  '0,               FUNC_SAMPLE,  16'd2048,  1'b0, 1'b0, 16'd0},
        '{ROW_ITEM,  '0,               FUNC_SAMPLE,  16'd1500,  1'b0, 1'b0, 16'd0},
        '{ROW_ITEM,  '0,               FUNC_SAMPLE,  16'd4095,  1'b1, 1'b1, 16'd32768},
        '{ROW_ITEM,  '0,               FUNC_RELEASE, 16'd4095,  1'b1, 1'b0, 16'd0},
        '{ROW_WRITE, CFG_CAL_LOW,      FUNC_SAMPLE,  16'd1000,  1'b0, 1'b0, 16'd0},
        '{ROW_WRITE, CFG_CAL_HIGH,     FUNC_SAMPLE,  16'd1000,  1'b0, 1'b0, 16'd0},
        '{ROW_ITEM,  '0,               FUNC_SAMPLE,  16'd4095,  1'b1, 1'b0, 16'd0},
        '{ROW_WRITE, CFG_CAL_LOW,      FUNC_SAMPLE,  16'hFBB8,  1'b0, 1'b0, 16'd0},
        '{ROW_WRITE, CFG_CAL_HIGH,     FUNC_SAMPLE,  16'd100,   1'b0, 1'b0, 16'd0},
        '{ROW_ITEM,  '0,               FUNC_SAMPLE,  16'd2000,  1'b1, 1'b0, 16'd0},
        '{ROW_WRITE, CFG_CAL_LOW,      FUNC_SAMPLE,  16'hF064,  1'b0, 1'b0, 16'd0},
        '{ROW_WRITE, CFG_CAL_HIGH,     FUNC_SAMPLE,  16'd4000,  1'b0, 1'b0, 16'd0},
        '{ROW_WRITE, CFG_ACTUATION,    FUNC_SAMPLE,  16'd0,     1'b0, 1'b0, 16'd0},
        '{ROW_WRITE, CFG_HYSTERESIS,   FUNC_SAMPLE,  16'd32768, 1'b0, 1'b0, 16'd0},
        '{ROW_WRITE, CFG_UNUSED,       FUNC_SAMPLE,  16'hFFFF,  1'b0, 1'b0, 16'd0},
        '{ROW_ITEM,  '0,               FUNC_SAMPLE,  16'd50,    1'b1, 1'b1, 16'd0},
        '{ROW_ITEM,  '0,               FUNC_SAMPLE,  16'd100,   1'b1, 1'b1, 16'd0},
        '{ROW_ITEM,  '0,               FUNC_SAMPLE,  16'd4000,  1'b1, 1'b1, 16'd32768},
        '{ROW_ITEM,  '0,               FUNC_SAMPLE,  16'd2050,  1'b0, 1'b0, 16'd0},
        '{ROW_ITEM,  '0,               FUNC_RELEASE, 16'd0,     1'b1, 1'b0, 16'd0},
        '{ROW_WRITE, CFG_ACTUATION,    FUNC_SAMPLE,  16'd65535, 1'b0, 1'b0, 16'd0},
        '{ROW_ITEM,  '0,               FUNC_SAMPLE,  16'd4095,  1'b1, 1'b0, 16'd32768},
        '{ROW_WRITE, CFG_CAL_LOW,      FUNC_SAMPLE,  16'd0,     1'b0, 1'b0, 16'd0},
        '{ROW_WRITE, CFG_CAL_HIGH,     FUNC_SAMPLE,  16'd4095,  1'b0, 1'b0, 16'd0},
        '{ROW_WRITE, CFG_TRIGGER_MODE, FUNC_SAMPLE,  16'd1,     1'b0, 1'b0, 16'd0},
        '{ROW_ITEM,  '0,               FUNC_SAMPLE,  16'd4095,  1'b1, 1'b1, 16'd32768},
        '{ROW_ITEM,  '0,               FUNC_SAMPLE,  16'd3000,  1'b0, 1'b0, 16'd0},
        '{ROW_ITEM,  '0,               FUNC_SAMPLE,  16'd3500,  1'b0, 1'b0, 16'd0},
        '{ROW_ITEM,  '0,               FUNC_SAMPLE,  16'd0,     1'b1, 1'b0, 16'd0},
        '{ROW_ITEM,  '0,               FUNC_SAMPLE,  16'd200,   1'b0, 1'b0, 16'd0},
        '{ROW_ITEM,  '0,               FUNC_SAMPLE,  16'd600,   1'b0, 1'b0, 16'd0},
        '{ROW_ITEM,  '0,               FUNC_RELEASE, 16'd4095,  1'b1, 1'b0, 16'd0},
        '{ROW_WRITE, CFG_RT_PRESS,     FUNC_SAMPLE,  16'd0,     1'b0, 1'b0, 16'd0},
        '{ROW_WRITE, CFG_RT_RELEASE,   FUNC_SAMPLE,  16'd65535, 1'b0, 1'b0, 16'd0},
        '{ROW_ITEM,  '0,               FUNC_SAMPLE,  16'd1,     1'b0, 1'b0, 16'd0},
        '{ROW_ITEM,  '0,               FUNC_SAMPLE,  16'd2,     1'b0, 1'b0, 16'd0},
        '{ROW_ITEM,  '0,               FUNC_SAMPLE,  16'd4094,  1'b0, 1'b0, 16'd0}
    };

    hall_key_rapid_trigger dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [POS_W-1:0] travel_of(logic [ADC_BITS-1:0] adc);
        int unsigned num;
        int unsigned span;
        if (cal_hi <= cal_lo || adc <= cal_lo) return '0;
        if (adc >= cal_hi) return FULL_POS;
        num  = (int'(adc) - int'(cal_lo)) << FRAC_BITS;
        span = int'(cal_hi) - int'(cal_lo);
        return POS_W'(num / span);
    endfunction

    function automatic key_report_t advance_key(logic func, logic [ADC_BITS-1:0] adc);
        key_report_t rep;
        logic [POS_W-1:0] pos;
        pos = '0;
        if (func == FUNC_RELEASE) begin
            key_down   = 1'b0;
            peak_pos   = '0;
            valley_pos = '0;
        end else begin
            pos = travel_of(adc);
            if (rapid_mode == MODE_RAPID) begin
                if (pos == 0 || pos >= FULL_POS) begin
                    peak_pos   = pos;
                    valley_pos = pos;
                    key_down   = (pos != 0);
                end else if (key_down) begin
                    if (pos > peak_pos) peak_pos = pos;
                    if (int'(pos) < int'(peak_pos) - int'(release_delta)) begin
                        key_down   = 1'b0;
                        valley_pos = pos;
                    end
                end else begin
                    if (pos < valley_pos) valley_pos = pos;
                    if (int'(pos) > int'(valley_pos) + int'(press_delta)) begin
                        key_down = 1'b1;
                        peak_pos = pos;
                    end
                end
            end else if (!key_down) begin
                if (pos >= actuation_lvl) key_down = 1'b1;
            end else if (int'(pos) < int'(actuation_lvl) - int'(hysteresis_lvl)) begin
                key_down = 1'b0;
            end
        end
        rep.pressed  = key_down;
        rep.position = pos;
        return rep;
    endfunction

    function automatic bit take_break(bit quiet);
        return !quiet && ($urandom_range(99) < 26);
    endfunction

    function automatic logic [15:0] pick_level(int typical);
        case ($urandom_range(7))
            0: return 16'd0;
            1: return 16'(FULL_POS);
            2: return 16'($urandom);
            default: return 16'($urandom_range(typical));
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        case (idx)
            CFG_CAL_LOW:      cal_lo = data[ADC_BITS-1:0];
            CFG_CAL_HIGH:     cal_hi = data[ADC_BITS-1:0];
            CFG_TRIGGER_MODE: rapid_mode = data[0];
            CFG_ACTUATION:    actuation_lvl = data;
            CFG_HYSTERESIS:   hysteresis_lvl = data;
            CFG_RT_PRESS:     press_delta = data;
            CFG_RT_RELEASE:   release_delta = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic push_item(input logic func, input logic [ADC_BITS-1:0] adc,
                             input bit typed, input key_report_t typed_rep);
        key_report_t rep;
        while (take_break(items_sent >= 400 && items_sent < 520)) @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {{(IN_DATA_W-ADC_BITS){1'b0}}, adc};
        s_axis_tuser  = func;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        rep = advance_key(func, adc);
        pending_reports.push_back(typed ? typed_rep : rep);
        items_sent++;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic wait_drain();
        while (pending_reports.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        key_report_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            reports_seen++;
            if (pending_reports.size() == 0) begin
                $error("key report with nothing pending: tdata %h", m_axis_tdata);
                fail_count++;
            end else begin
                want = pending_reports.pop_front();
                if (m_axis_tdata[0] !== want.pressed) begin
                    $error("key_pressed expected %0d actual %0d", want.pressed,
                           m_axis_tdata[0]);
                    fail_count++;
                end
                if (m_axis_tdata[POS_W:1] !== want.position) begin
                    $error("key_position expected %0d actual %0d", want.position,
                           m_axis_tdata[POS_W:1]);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        bit held;
        held = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && reports_seen >= 150) begin
                // hold off so the input side backs up
                held = 1'b1;
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            m_axis_tready = !take_break(reports_seen >= 560 && reports_seen < 680);
        end
    end

    initial begin
        #(64'd6_000_000);
        $display("hall_key_rapid_trigger verification failed");
        $finish;
    end

    initial begin
        int lo, hi, cur, target, span, step, r, n;
        logic [ADC_BITS-1:0] adc;
        logic func;
        script_row_t row;
        cur = 0;
        target = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < SCRIPT_LEN; i++) begin
            row = script_rows[i];
            if (row.kind == ROW_WRITE) begin
                wait_drain();
                write_reg(row.index, row.value);
            end else begin
                push_item(row.func, row.value[ADC_BITS-1:0], row.typed,
                          key_report_t'{row.exp_pressed, row.exp_pos});
            end
        end

        for (int phase = 0; phase < 8; phase++) begin
            wait_drain();
            case (phase < 2 ? 4 : (phase == 2 ? 1 : (phase == 3 ? 3 : $urandom_range(9))))
                0: begin lo = 0; hi = 4095; end
                1: begin lo = 4094; hi = 4095; end
                2: begin lo = 0; hi = 1; end
                3: begin lo = $urandom_range(4095); hi = $urandom_range(lo); end
                4: begin lo = $urandom_range(100); hi = $urandom_range(4095, 3900); end
                default: begin lo = $urandom_range(2000); hi = $urandom_range(4095, lo + 1); end
            endcase
            write_reg(CFG_CAL_LOW, {4'($urandom), 12'(lo)});
            write_reg(CFG_CAL_HIGH, {4'($urandom), 12'(hi)});
            write_reg(CFG_TRIGGER_MODE,
                      {15'($urandom), (phase % 2 == 1) ? MODE_RAPID : MODE_TRADITIONAL});
            write_reg(CFG_ACTUATION, pick_level(32768));
            write_reg(CFG_HYSTERESIS, pick_level(8000));
            write_reg(CFG_RT_PRESS, pick_level(6000));
            write_reg(CFG_RT_RELEASE, pick_level(6000));
            span = (hi > lo) ? hi - lo : 4095;
            n = $urandom_range(115, 95);
            repeat (n) begin
                r = $urandom_range(99);
                func = FUNC_SAMPLE;
                if (r < 4) begin
                    func = FUNC_RELEASE;
                    adc = ADC_BITS'($urandom);
                end else if (r < 12) begin
                    adc = ADC_BITS'($urandom);
                end else begin
                    // sweep the key toward a travel target
                    if (cur == target) begin
                        case ($urandom_range(5))
                            0: target = 0;
                            1: target = 4095;
                            2: target = lo;
                            3: target = hi;
                            default: target = (lo < hi) ? $urandom_range(hi, lo)
                                                        : $urandom_range(4095);
                        endcase
                    end
                    step = $urandom_range(1 + span / 6, 1);
                    if (cur < target) cur = (cur + step > target) ? target : cur + step;
                    else if (cur > target) cur = (cur - step < target) ? target : cur - step;
                    adc = cur[ADC_BITS-1:0];
                end
                push_item(func, adc, 1'b0, key_report_t'('0));
            end
        end

        wait_drain();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("hall_key_rapid_trigger verification clean");
        end else begin
            $display("hall_key_rapid_trigger verification failed");
        end
        $finish;
    end

endmodule
